>>> hdl/dar_pkg.sv
// ----------------------------------------------------------------------------
// dar_pkg: shared constants and types for the display aspect ratio reducer
// Field widths, datapath widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package dar_pkg;

  // Significant bits of the coded width and height
  localparam int DIM_BITS     = 16;
  // Port field widths
  localparam int DIM_FIELD_W  = 16;
  localparam int SAR_W        = 16;
  localparam int WIDE_FIELD_W = 32;

  // Datapath widths
  localparam int PROD_W    = DIM_BITS + SAR_W;   // width * sar_num
  localparam int DVD_W     = PROD_W + 1;         // 2 * prod + den
  localparam int DVS_W     = SAR_W + 1;          // 2 * den, also holds the gcd
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int SHIFT_W   = $clog2(DIM_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_SCALE,
    ST_CHECK,
    ST_GCD,
    ST_QX,
    ST_QY,
    ST_OUT
  } dar_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } dar_unit_stat_t;

endpackage

>>> hdl/dar_if.sv
// ----------------------------------------------------------------------------
// dar_if: request and result channels of the display aspect ratio reducer
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dar_in_if;
  import dar_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DIM_FIELD_W-1:0] coded_width;
  logic [DIM_FIELD_W-1:0] coded_height;
  logic [SAR_W-1:0]       sar_num;
  logic [SAR_W-1:0]       sar_den;

  modport source (
    output valid, coded_width, coded_height, sar_num, sar_den,
    input  ready
  );
  modport sink (
    input  valid, coded_width, coded_height, sar_num, sar_den,
    output ready
  );
endinterface

interface dar_out_if;
  import dar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [WIDE_FIELD_W-1:0] display_width;
  logic [DIM_FIELD_W-1:0]  display_height;
  logic [WIDE_FIELD_W-1:0] ratio_x;
  logic [DIM_FIELD_W-1:0]  ratio_y;

  modport source (
    output valid, display_width, display_height, ratio_x, ratio_y,
    input  ready
  );
  modport sink (
    input  valid, display_width, display_height, ratio_x, ratio_y,
    output ready
  );
endinterface

>>> hdl/dar_div.sv
// ----------------------------------------------------------------------------
// dar_div: iterative restoring divider
// One quotient bit per cycle; done pulses once per division.
// ----------------------------------------------------------------------------
module dar_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dar_pkg::DVD_W-1:0]      dividend_i,
  input  logic [dar_pkg::DVS_W-1:0]      divisor_i,
  output logic [dar_pkg::DVD_W-1:0]      quotient_o,
  output dar_pkg::dar_unit_stat_t        stat_o
);
  import dar_pkg::*;

  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DVS_W:0]       trial;
  logic [DVS_W+1:0]     diff;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DVD_W - 1);
    end else if (busy_q) begin
      busy_q <= (cnt_q != '0);
      done_q <= (cnt_q == '0);
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (diff[DVS_W+1]) begin
        rem_q <= trial[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end else begin
        rem_q <= diff[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

>>> hdl/dar_gcd.sv
// ----------------------------------------------------------------------------
// dar_gcd: iterative binary GCD
// One shift or subtract-and-shift step per cycle; both operands nonzero.
// ----------------------------------------------------------------------------
module dar_gcd (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dar_pkg::PROD_W-1:0]     a_i,
  input  logic [dar_pkg::DIM_BITS-1:0]   b_i,
  output logic [dar_pkg::DIM_BITS-1:0]   g_o,
  output dar_pkg::dar_unit_stat_t        stat_o
);
  import dar_pkg::*;

  logic [PROD_W-1:0]   a_q;
  logic [PROD_W-1:0]   b_q;
  logic [SHIFT_W-1:0]  k_q;
  logic [DIM_BITS-1:0] g_q;
  logic                busy_q;
  logic                done_q;
  logic                a_gt;
  logic                eq;
  logic [PROD_W-1:0]   diff;
  logic [PROD_W-1:0]   shifted;

  assign a_gt    = (a_q > b_q);
  assign eq      = (a_q == b_q);
  assign diff    = a_gt ? (a_q - b_q) : (b_q - a_q);
  assign shifted = a_q << k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && eq) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= PROD_W'(b_i);
      k_q <= '0;
    end else if (busy_q) begin
      if (eq) begin
        // common power of two restored; the gcd never exceeds b
        g_q <= shifted[DIM_BITS-1:0];
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + SHIFT_W'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_gt) begin
        a_q <= diff >> 1;
      end else begin
        b_q <= diff >> 1;
      end
    end
  end

  assign g_o         = g_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> hdl/display_aspect_ratio_reducer.sv
// ----------------------------------------------------------------------------
// display_aspect_ratio_reducer: display size and reduced aspect ratio
// From request to result: setup and check states, up to three divisions of 33
// quotient bits each and a binary GCD loop. One request at a time: the next
// request can be taken the cycle after the result leaves.
// Reset clears the sequencer and unit control; no memory, no clearing pass.
// ----------------------------------------------------------------------------
module display_aspect_ratio_reducer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dar_in_if.sink    in_i,
  dar_out_if.source out_o
);
  import dar_pkg::*;

  dar_state_e          state_q, state_d;
  logic [DIM_BITS-1:0] w_q;
  logic [DIM_BITS-1:0] h_q;
  logic [SAR_W-1:0]    num_q;
  logic [SAR_W-1:0]    den_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   dw_q;
  logic [PROD_W-1:0]   ax_q;
  logic [DIM_BITS-1:0] ay_q;
  logic                sar_ok;

  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [DVD_W-1:0]    div_quo;
  dar_unit_stat_t      div_stat;

  logic                gcd_start;
  logic [DIM_BITS-1:0] gcd_g;
  dar_unit_stat_t      gcd_stat;

  assign sar_ok = (num_q != '0) && (den_q != '0);

  dar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  dar_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (dw_q),
    .b_i     (h_q),
    .g_o     (gcd_g),
    .stat_o  (gcd_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    gcd_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if (sar_ok) begin
          // round half up: (2*w*num + den) / (2*den)
          div_start = 1'b1;
          div_dvd   = {prod_q, 1'b0} + DVD_W'(den_q);
          div_dvs   = {den_q, 1'b0};
          state_d   = ST_SCALE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_SCALE: begin
        if (div_stat.done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (dw_q == '0 || h_q == '0) begin
          state_d = ST_OUT;
        end else begin
          gcd_start = 1'b1;
          state_d   = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_stat.done) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(dw_q);
          div_dvs   = DVS_W'(gcd_g);
          state_d   = ST_QX;
        end
      end
      ST_QX: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(h_q);
          div_dvs   = DVS_W'(gcd_g);
          state_d   = ST_QY;
        end
      end
      ST_QY: begin
        if (div_stat.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          w_q   <= in_i.coded_width[DIM_BITS-1:0];
          h_q   <= in_i.coded_height[DIM_BITS-1:0];
          num_q <= in_i.sar_num;
          den_q <= in_i.sar_den;
        end
      end
      ST_MUL: begin
        prod_q <= PROD_W'(w_q) * PROD_W'(num_q);
      end
      ST_PREP: begin
        dw_q <= PROD_W'(w_q);
      end
      ST_SCALE: begin
        if (div_stat.done) dw_q <= div_quo[PROD_W-1:0];
      end
      ST_CHECK: begin
        // 1:1 unless the gcd path overwrites
        ax_q <= PROD_W'(1);
        ay_q <= DIM_BITS'(1);
      end
      ST_QX: begin
        if (div_stat.done) ax_q <= div_quo[PROD_W-1:0];
      end
      ST_QY: begin
        if (div_stat.done) ay_q <= div_quo[DIM_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = (state_q == ST_OUT);
  assign out_o.display_width  = WIDE_FIELD_W'(dw_q);
  assign out_o.display_height = DIM_FIELD_W'(h_q);
  assign out_o.ratio_x        = WIDE_FIELD_W'(ax_q);
  assign out_o.ratio_y        = DIM_FIELD_W'(ay_q);

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("division started while divider busy");

  a_gcd_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_start |-> !gcd_stat.busy)
    else $error("gcd started while gcd unit busy");

  a_aspect_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.ratio_x != '0 && out_o.ratio_y != '0))
    else $error("zero aspect term in result");

  a_zero_dim_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.display_width == '0 || out_o.display_height == '0))
      |-> (out_o.ratio_x == WIDE_FIELD_W'(1) && out_o.ratio_y == DIM_FIELD_W'(1)))
    else $error("zero dimension must give 1:1");

endmodule

>>> tb/sv/display_aspect_ratio_reducer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_aspect_ratio_reducer_test: testbench for the aspect ratio reducer
// Sends a table of directed requests, then random ones. Each result is checked
// against the row's expected result where the table gives one, else against a
// predictor that does the scaling with exact integers and the reduction with
// Euclid's algorithm. Both channels stall at random.
module display_aspect_ratio_reducer_test;
  import dar_pkg::*;

  localparam int          N_RANDOM     = 1230;
  localparam int          STALL_LIMIT  = 4000;  // cycles with no transfer on either channel
  localparam int          DRAIN_LENGTH = 250;   // > slowest request
  localparam int          HOLD_AT      = 300;   // results seen before the long hold-off
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_AT     = 700;   // random request after which the sender drains
  localparam int          PRINT_LIMIT  = 20;

  typedef struct packed {
    logic [DIM_FIELD_W-1:0] coded_width;
    logic [DIM_FIELD_W-1:0] coded_height;
    logic [SAR_W-1:0]       sar_num;
    logic [SAR_W-1:0]       sar_den;
  } dar_request_t;

  typedef struct packed {
    logic [WIDE_FIELD_W-1:0] display_width;
    logic [DIM_FIELD_W-1:0]  display_height;
    logic [WIDE_FIELD_W-1:0] ratio_x;
    logic [DIM_FIELD_W-1:0]  ratio_y;
  } dar_display_t;

  // typed = 1: the display fields of the row are the expected result
  typedef struct packed {
    logic         typed;
    dar_request_t req;
    dar_display_t disp;
  } dar_vector_t;

  localparam int N_DIRECTED = 19;
  localparam dar_vector_t DIRECTED [N_DIRECTED] = '{
    // all zero
    '{1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}, '{32'd0, 16'd0, 32'd1, 16'd1}},
    // unknown aspect, largest dimensions
    '{1'b1, '{16'd65535, 16'd65535, 16'd0, 16'd0},
            '{32'd65535, 16'd65535, 32'd1, 16'd1}},
    // widest product
    '{1'b1, '{16'd65535, 16'd65535, 16'd65535, 16'd1},
            '{32'd4294836225, 16'd65535, 32'd65535, 16'd1}},
    '{1'b1, '{16'd65535, 16'd65535, 16'd1, 16'd65535},
            '{32'd1, 16'd65535, 32'd1, 16'd65535}},
    // scales down to zero width
    '{1'b1, '{16'd1, 16'd1, 16'd1, 16'd65535}, '{32'd0, 16'd1, 32'd1, 16'd1}},
    // exact halves round up
    '{1'b1, '{16'd1, 16'd1, 16'd1, 16'd2}, '{32'd1, 16'd1, 32'd1, 16'd1}},
    '{1'b1, '{16'd3, 16'd1, 16'd1, 16'd2}, '{32'd2, 16'd1, 32'd2, 16'd1}},
    // zero width, zero height
    '{1'b1, '{16'd0, 16'd1080, 16'd4, 16'd3}, '{32'd0, 16'd1080, 32'd1, 16'd1}},
    '{1'b1, '{16'd1920, 16'd0, 16'd1, 16'd1}, '{32'd1920, 16'd0, 32'd1, 16'd1}},
    // one term of the aspect unknown
    '{1'b1, '{16'd640, 16'd480, 16'd0, 16'd5}, '{32'd640, 16'd480, 32'd4, 16'd3}},
    '{1'b1, '{16'd640, 16'd480, 16'd7, 16'd0}, '{32'd640, 16'd480, 32'd4, 16'd3}},
    '{1'b1, '{16'd1920, 16'd1080, 16'd1, 16'd1},
            '{32'd1920, 16'd1080, 32'd16, 16'd9}},
    '{1'b1, '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
            '{32'd65535, 16'd65535, 32'd1, 16'd1}},
    '{1'b1, '{16'd1, 16'd65535, 16'd65535, 16'd1},
            '{32'd65535, 16'd65535, 32'd1, 16'd1}},
    '{1'b0, '{16'd720, 16'd576, 16'd16, 16'd15}, '0},
    '{1'b0, '{16'd720, 16'd480, 16'd32, 16'd27}, '0},
    '{1'b0, '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}, '0},
    '{1'b0, '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}, '0},
    '{1'b0, '{16'd4095, 16'd2047, 16'd3, 16'd1}, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dar_in_if  req_if ();
  dar_out_if disp_if ();

  display_aspect_ratio_reducer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (disp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dar_display_t pending_displays[$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  idle_cycles;
  bit           sender_quiet   = 1'b0;

  // Round-half-up scaling of the width, then reduction by the gcd
  function automatic dar_display_t predict_display(input dar_request_t r);
    logic [63:0]  dim_mask;
    logic [63:0]  w;
    logic [63:0]  h;
    logic [63:0]  dw;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  t;
    dar_display_t d;
    dim_mask = (64'd1 << DIM_BITS) - 64'd1;
    w  = {48'd0, r.coded_width} & dim_mask;
    h  = {48'd0, r.coded_height} & dim_mask;
    dw = w;
    if (r.sar_num != '0 && r.sar_den != '0)
      dw = (2 * w * r.sar_num + r.sar_den) / (2 * {48'd0, r.sar_den});
    d.display_width  = dw[WIDE_FIELD_W-1:0];
    d.display_height = h[DIM_FIELD_W-1:0];
    d.ratio_x        = WIDE_FIELD_W'(1);
    d.ratio_y        = DIM_FIELD_W'(1);
    if (dw != 0 && h != 0) begin
      a = dw;
      b = h;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      d.ratio_x = WIDE_FIELD_W'(dw / a);
      d.ratio_y = DIM_FIELD_W'(h / a);
    end
    return d;
  endfunction

  function automatic logic [DIM_FIELD_W-1:0] random_dim();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5)       return '0;
    else if (p < 30) return DIM_FIELD_W'($urandom);
    else if (p < 50) return DIM_FIELD_W'($urandom_range(1, 64));
    else             return DIM_FIELD_W'($urandom_range(16, 4096));
  endfunction

  function automatic dar_request_t random_request();
    dar_request_t r;
    int unsigned  p;
    r.coded_width  = random_dim();
    r.coded_height = random_dim();
    r.sar_num      = SAR_W'($urandom_range(1, 100));
    r.sar_den      = SAR_W'($urandom_range(1, 100));
    p = $urandom_range(0, 99);
    if (p < 8) begin
      r.sar_num = '0;
    end else if (p < 16) begin
      r.sar_den = '0;
    end else if (p < 20) begin
      r.sar_num = '0;
      r.sar_den = '0;
    end else if (p < 55) begin
      // sample aspects seen in real streams
      case ($urandom_range(0, 7))
        0: begin r.sar_num = 16'd1;  r.sar_den = 16'd1;  end
        1: begin r.sar_num = 16'd4;  r.sar_den = 16'd3;  end
        2: begin r.sar_num = 16'd16; r.sar_den = 16'd15; end
        3: begin r.sar_num = 16'd64; r.sar_den = 16'd45; end
        4: begin r.sar_num = 16'd10; r.sar_den = 16'd11; end
        5: begin r.sar_num = 16'd40; r.sar_den = 16'd33; end
        6: begin r.sar_num = 16'd32; r.sar_den = 16'd27; end
        default: begin r.sar_num = 16'd8; r.sar_den = 16'd9; end
      endcase
    end else if (p >= 80) begin
      r.sar_num = SAR_W'($urandom);
      r.sar_den = SAR_W'($urandom);
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55)      return 0;
    else if (p < 85) return $urandom_range(1, 3);
    else if (p < 97) return $urandom_range(4, 12);
    else             return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0d want %0d",
               results_seen, what, got, want);
  endtask

  task automatic check_display(input dar_display_t got);
    dar_display_t want;
    if (pending_displays.size() == 0) begin
      report_mismatch("result with no request pending", 32'd0, 32'd0);
      return;
    end
    want = pending_displays.pop_front();
    if (got.display_width !== want.display_width)
      report_mismatch("display_width", got.display_width, want.display_width);
    if (got.display_height !== want.display_height)
      report_mismatch("display_height", 32'(got.display_height),
                      32'(want.display_height));
    if (got.ratio_x !== want.ratio_x)
      report_mismatch("ratio_x", got.ratio_x, want.ratio_x);
    if (got.ratio_y !== want.ratio_y)
      report_mismatch("ratio_y", 32'(got.ratio_y), 32'(want.ratio_y));
  endtask

  task automatic send_request(input dar_request_t r, input logic typed,
                              input dar_display_t typed_disp);
    req_if.valid        <= 1'b1;
    req_if.coded_width  <= r.coded_width;
    req_if.coded_height <= r.coded_height;
    req_if.sar_num      <= r.sar_num;
    req_if.sar_den      <= r.sar_den;
    do @(posedge clk_i); while (!req_if.ready);
    pending_displays.push_back(typed ? typed_disp : predict_display(r));
  endtask

  // Gap after a request; a drain waits until every result is back
  task automatic pause_sender(input bit drain);
    int unsigned gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (drain && gap == 0)
      gap = 1;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && pending_displays.size() != 0) @(posedge clk_i);
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (disp_if.valid && disp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : display_sink
    int unsigned  stall_left;
    bit           hold_done;
    dar_display_t got;
    stall_left    = 0;
    hold_done     = 1'b0;
    disp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (disp_if.valid && disp_if.ready) begin
        got.display_width  = disp_if.display_width;
        got.display_height = disp_if.display_height;
        got.ratio_x        = disp_if.ratio_x;
        got.ratio_y        = disp_if.ratio_y;
        check_display(got);
        results_seen++;
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        // long hold-off while the sender keeps offering
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && (results_seen < 700 || results_seen >= 850)
                   && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        disp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        disp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : request_source
    int unsigned  n;
    dar_request_t r;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.coded_width  = '0;
    req_if.coded_height = '0;
    req_if.sar_num      = '0;
    req_if.sar_den      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < N_DIRECTED; n++) begin
      send_request(DIRECTED[n].req, DIRECTED[n].typed, DIRECTED[n].disp);
      pause_sender(1'b0);
    end

    for (n = 0; n < N_RANDOM; n++) begin
      // back to back around the long hold-off on the result side
      sender_quiet = (n >= 250 && n < 450);
      r = random_request();
      send_request(r, 1'b0, '0);
      pause_sender(n == DRAIN_AT || $urandom_range(0, 199) == 0);
    end
    req_if.valid <= 1'b0;

    while (pending_displays.size() != 0) @(posedge clk_i);
    repeat (DRAIN_LENGTH) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
